// File: src/demand_paged_memory_macros.svh
// assertion macros used by the demand_paged_memory module
// no dependencies; each macro expects clk and rst_n in the enclosing scope
`ifndef DEMAND_PAGED_MEMORY_MACROS_SVH
`define DEMAND_PAGED_MEMORY_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define DPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/dpm_pkg.sv
// shared types, codes and helpers of the demand-paged memory
// no dependencies; imported by every other file of the block but the macro header
package dpm_pkg;

  localparam int CMD_W   = 3;
  localparam int ADDR_W  = 32;
  localparam int WDATA_W = 64;
  localparam int RDATA_W = 32;

  // access commands
  typedef enum logic [CMD_W-1:0] {
    CMD_RD_WORD  = 3'd0,
    CMD_WR_BYTE  = 3'd1,
    CMD_WR_HALF  = 3'd2,
    CMD_WR_WORD  = 3'd3,
    CMD_WR_DBL   = 3'd4,
    CMD_WR_RD    = 3'd5
  } dpm_cmd_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_ZERO,
    S_WRITE,
    S_READ,
    S_DONE
  } dpm_state_t;

  // sequencer to tag unit
  typedef struct packed {
    logic start;
    logic alloc;
  } dpm_tag_ctrl_t;

  // tag unit to sequencer
  typedef struct packed {
    logic hit;
    logic miss;
    logic full;
  } dpm_tag_stat_t;

  // sequencer to byte store
  typedef struct packed {
    logic we;
    logic re;
  } dpm_store_ctrl_t;

  // true for the six defined commands
  function automatic logic cmd_is_valid(input logic [CMD_W-1:0] cmd);
    return (cmd == CMD_RD_WORD) || (cmd == CMD_WR_BYTE) || (cmd == CMD_WR_HALF) ||
           (cmd == CMD_WR_WORD) || (cmd == CMD_WR_DBL) || (cmd == CMD_WR_RD);
  endfunction

  // index of the last byte a write command stores
  function automatic logic [2:0] last_byte(input logic [CMD_W-1:0] cmd);
    logic [2:0] lb;
    unique case (cmd)
      CMD_WR_BYTE: lb = 3'd0;
      CMD_WR_HALF: lb = 3'd1;
      CMD_WR_DBL:  lb = 3'd7;
      default:     lb = 3'd3;
    endcase
    return lb;
  endfunction

endpackage

// File: src/dpm_chan_if.sv
// valid/ready channel interfaces for access requests and results
// depends on dpm_pkg for the field widths
interface dpm_in_if;
  import dpm_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [ADDR_W-1:0]  addr;
  logic [WDATA_W-1:0] write_data;

  modport source (output valid, cmd, addr, write_data, input ready);
  modport sink   (input valid, cmd, addr, write_data, output ready);
endinterface

interface dpm_out_if;
  import dpm_pkg::*;

  logic               valid;
  logic               ready;
  logic [RDATA_W-1:0] read_data;
  logic               page_was_new;
  logic               out_of_pages;

  modport source (output valid, read_data, page_was_new, out_of_pages, input ready);
  modport sink   (input valid, read_data, page_was_new, out_of_pages, output ready);
endinterface

// File: src/demand_paged_memory.sv
// Demand-paged byte memory with on-demand page allocation.
// Input channel in_chan (valid/ready) carries cmd, addr and write_data; the
// result channel out_chan carries read_data, page_was_new and out_of_pages,
// exactly one result per accepted request. One request is worked at a time;
// in_chan.ready is high only while the sequencer is idle.
// A request runs through these steps in order:
//   tag search     one tag compare per cycle, in allocation order of the pages
//   new page       on a miss, zeroing, one byte per cycle through the store
//   write          1, 2, 4 or 8 bytes, one byte per cycle on the store port
//   read           four byte reads, registered (skipped for a read of a new page)
//   result         accept and output register
// Undefined commands return an all-zero result.
// The result sits in an output register; if the receiver stalls, the block
// finishes the next request up to its result and waits there.
// Reset (rst_n, synchronous) empties the page table and the output register;
// page contents are not cleared by reset, a page is zeroed when allocated.
module demand_paged_memory #(
  parameter int PAGE_BYTES = 4096,
  parameter int MAX_PAGES  = 16
) (
  input logic      clk,
  input logic      rst_n,
  dpm_in_if.sink   in_chan,
  dpm_out_if.source out_chan
);
  import dpm_pkg::*;

  localparam int OFF_W = $clog2(PAGE_BYTES);
  localparam int VPN_W = ADDR_W - OFF_W;
  localparam int PG_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int SA_W  = PG_W + OFF_W;
  localparam int DEPTH = MAX_PAGES * PAGE_BYTES;

  dpm_state_t         state_r, state_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [WDATA_W-1:0] data_r, data_nxt;
  logic [PG_W-1:0]    page_r, page_nxt;
  logic [OFF_W-1:0]   zoff_r, zoff_nxt;
  logic [2:0]         k_r, k_nxt;
  logic               rpend_r, rpend_nxt;
  logic               fresh_r, fresh_nxt;
  logic               oop_r, oop_nxt;
  logic [RDATA_W-1:0] rd_r, rd_nxt;

  logic               ovalid_r, ovalid_nxt;
  logic [RDATA_W-1:0] ordata_r, ordata_nxt;
  logic               onew_r, onew_nxt;
  logic               ooop_r, ooop_nxt;

  dpm_tag_ctrl_t      tag_ctrl;
  dpm_tag_stat_t      tag_stat;
  logic [PG_W-1:0]    tag_page;
  dpm_store_ctrl_t    st_ctrl;
  logic [SA_W-1:0]    st_addr;
  logic [7:0]         st_wdata;
  logic [7:0]         st_rdata;
  logic [OFF_W-1:0]   off_k;
  logic               in_xfer;

  assign in_chan.ready          = (state_r == S_IDLE);
  assign in_xfer                = in_chan.valid && in_chan.ready;
  assign out_chan.valid         = ovalid_r;
  assign out_chan.read_data     = ordata_r;
  assign out_chan.page_was_new  = onew_r;
  assign out_chan.out_of_pages  = ooop_r;

  // byte offset within the page, wrapping at the page end
  assign off_k = addr_r[OFF_W-1:0] + OFF_W'(k_r);

  dpm_tag_unit #(
    .VPN_W     (VPN_W),
    .MAX_PAGES (MAX_PAGES)
  ) u_tag (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (tag_ctrl),
    .vpn   (addr_r[ADDR_W-1:OFF_W]),
    .stat  (tag_stat),
    .page  (tag_page)
  );

  dpm_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (SA_W)
  ) u_store (
    .clk   (clk),
    .ctrl  (st_ctrl),
    .addr  (st_addr),
    .wdata (st_wdata),
    .rdata (st_rdata)
  );

  // sequencer next state and datapath control
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    addr_nxt   = addr_r;
    data_nxt   = data_r;
    page_nxt   = page_r;
    zoff_nxt   = zoff_r;
    k_nxt      = k_r;
    rpend_nxt  = 1'b0;
    fresh_nxt  = fresh_r;
    oop_nxt    = oop_r;
    rd_nxt     = rd_r;
    ovalid_nxt = ovalid_r && !out_chan.ready;
    ordata_nxt = ordata_r;
    onew_nxt   = onew_r;
    ooop_nxt   = ooop_r;
    tag_ctrl   = '0;
    st_ctrl    = '0;
    st_addr    = {page_r, off_k};
    st_wdata   = data_r[7:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt   = in_chan.cmd;
          addr_nxt  = in_chan.addr;
          data_nxt  = in_chan.write_data;
          fresh_nxt = 1'b0;
          oop_nxt   = 1'b0;
          rd_nxt    = '0;
          k_nxt     = '0;
          zoff_nxt  = '0;
          if (cmd_is_valid(in_chan.cmd)) begin
            tag_ctrl.start = 1'b1;
            state_nxt      = S_SEARCH;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_SEARCH: begin
        priority if (tag_stat.hit) begin
          page_nxt  = tag_page;
          state_nxt = (cmd_r == CMD_RD_WORD) ? S_READ : S_WRITE;
        end else if (tag_stat.miss && tag_stat.full) begin
          oop_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (tag_stat.miss) begin
          tag_ctrl.alloc = 1'b1;
          page_nxt       = tag_page;
          fresh_nxt      = 1'b1;
          state_nxt      = S_ZERO;
        end else begin
          state_nxt = S_SEARCH;
        end
      end

      // clear the new page one byte per cycle
      S_ZERO: begin
        st_ctrl.we = 1'b1;
        st_addr    = {page_r, zoff_r};
        st_wdata   = '0;
        zoff_nxt   = zoff_r + OFF_W'(1);
        if (zoff_r == {OFF_W{1'b1}}) begin
          state_nxt = (cmd_r == CMD_RD_WORD) ? S_DONE : S_WRITE;
        end
      end

      // store the low bytes little-endian
      S_WRITE: begin
        st_ctrl.we = 1'b1;
        data_nxt   = data_r >> 8;
        k_nxt      = k_r + 3'd1;
        if (k_r == last_byte(cmd_r)) begin
          k_nxt     = '0;
          state_nxt = (cmd_r == CMD_WR_RD) ? S_READ : S_DONE;
        end
      end

      // four byte reads, each shifted into the top byte in the cycle after its read
      S_READ: begin
        st_ctrl.re = (k_r < 3'd4);
        rpend_nxt  = st_ctrl.re;
        if (st_ctrl.re) begin
          k_nxt = k_r + 3'd1;
        end
        if (rpend_r) begin
          rd_nxt = {st_rdata, rd_r[RDATA_W-1:8]};
        end
        if ((k_r == 3'd4) && !rpend_r) begin
          state_nxt = S_DONE;
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!ovalid_r || out_chan.ready) begin
          ovalid_nxt = 1'b1;
          ordata_nxt = rd_r;
          onew_nxt   = fresh_r;
          ooop_nxt   = oop_r;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      rpend_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      rpend_r  <= rpend_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    addr_r   <= addr_nxt;
    data_r   <= data_nxt;
    page_r   <= page_nxt;
    zoff_r   <= zoff_nxt;
    k_r      <= k_nxt;
    fresh_r  <= fresh_nxt;
    oop_r    <= oop_nxt;
    rd_r     <= rd_nxt;
    ordata_r <= ordata_nxt;
    onew_r   <= onew_nxt;
    ooop_r   <= ooop_nxt;
  end

`include "demand_paged_memory_macros.svh"

  // a dropped access never reports a new page or read data
  `DPM_ASSERT_IMP(a_oop_clean, ovalid_r && ooop_r, !onew_r && (ordata_r == '0), "dropped access result not clean")
  // the tag search never reports hit and miss together
  `DPM_ASSERT_IMP(a_hit_miss, state_r == S_SEARCH, !(tag_stat.hit && tag_stat.miss), "tag hit and miss at once")
  // the store port is never read and written in one cycle
  `DPM_ASSERT_IMP(a_port_excl, st_ctrl.we, !st_ctrl.re, "store read and write collide")
  // an undefined command goes straight to the result
  `DPM_ASSERT_NXT(a_bad_cmd, in_xfer && !cmd_is_valid(in_chan.cmd), state_r == S_DONE, "undefined command not skipped")
  // an allocation marks the result as a new page and moves on to zeroing
  `DPM_ASSERT_NXT(a_alloc_fresh, tag_ctrl.alloc, fresh_r && (state_r == S_ZERO), "allocation without zeroing")

endmodule

// File: src/dpm_tag_unit.sv
// page tag memory, allocation count and the shared sequential tag compare
// depends on dpm_pkg for the control and status structs
module dpm_tag_unit #(
  parameter int VPN_W     = 20,
  parameter int MAX_PAGES = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  dpm_pkg::dpm_tag_ctrl_t                      ctrl,
  input  logic [VPN_W-1:0]                            vpn,
  output dpm_pkg::dpm_tag_stat_t                      stat,
  output logic [((MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1)-1:0] page
);
  import dpm_pkg::*;

  localparam int PG_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W = $clog2(MAX_PAGES + 1);

  logic [VPN_W-1:0] tags [MAX_PAGES];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             srch_r, srch_nxt;
  logic             pend_r, pend_nxt;
  logic [PG_W-1:0]  pend_idx_r;
  logic [VPN_W-1:0] tag_q_r;
  logic             issue;

  // compare of the entry read last cycle, miss once every entry has been seen
  assign issue     = srch_r && (idx_r < count_r);
  assign stat.hit  = srch_r && pend_r && (tag_q_r == vpn);
  assign stat.miss = srch_r && !pend_r && (idx_r == count_r);
  assign stat.full = (count_r == CNT_W'(MAX_PAGES));
  assign page      = stat.hit ? pend_idx_r : count_r[PG_W-1:0];

  // search walk and allocation count
  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    srch_nxt  = srch_r;
    pend_nxt  = pend_r;
    if (ctrl.alloc) begin
      count_nxt = count_r + CNT_W'(1);
    end
    priority if (ctrl.start) begin
      idx_nxt  = '0;
      srch_nxt = 1'b1;
      pend_nxt = 1'b0;
    end else if (stat.hit || stat.miss) begin
      srch_nxt = 1'b0;
      pend_nxt = 1'b0;
    end else begin
      // walking, or idle where issue stays low and nothing moves
      pend_nxt = issue;
      if (issue) begin
        idx_nxt = idx_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      srch_r  <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      srch_r  <= srch_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // tag memory: one registered read, one write
  always_ff @(posedge clk) begin
    if (issue) begin
      tag_q_r    <= tags[idx_r[PG_W-1:0]];
      pend_idx_r <= idx_r[PG_W-1:0];
    end
    if (ctrl.alloc) begin
      tags[count_r[PG_W-1:0]] <= vpn;
    end
  end

endmodule

// File: src/dpm_store.sv
// byte-wide physical page store, one access per cycle, registered read
// depends on dpm_pkg for the control struct
module dpm_store #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  logic                     clk,
  input  dpm_pkg::dpm_store_ctrl_t ctrl,
  input  logic [ADDR_W-1:0]        addr,
  input  logic [7:0]               wdata,
  output logic [7:0]               rdata
);
  import dpm_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  assign rdata = rdata_r;

  // single-port byte memory
  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[addr] <= wdata;
    end
    if (ctrl.re) begin
      rdata_r <= mem[addr];
    end
  end

endmodule
